// ----- rtl/core/kvb_pkg.sv -----
`timescale 1ns / 1ps

package kvb_pkg;

	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// operation codes carried in the func field
	localparam logic [1:0] FUNC_GET    = 2'd0;
	localparam logic [1:0] FUNC_PUT    = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] key;
		logic [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] value_out;
		logic        full_error;
		logic [4:0]  entry_count;
	} rsp_t;

endpackage

// ----- rtl/core/kvb_if.sv -----
`timescale 1ns / 1ps

interface kvb_req_if;
	import kvb_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface kvb_rsp_if;
	import kvb_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/key_value_bucket_store.sv -----
`timescale 1ns / 1ps

// One hash bucket holding up to DEPTH key/value pairs with unique keys.
// Each request (get, put or remove) is served by a linear search: the key
// memory has a single read port, so stored keys are compared one per cycle.
// The search stops at a matching entry, or after the last entry if the key
// is absent; the update follows, and it waits while the output register still
// holds a result not yet taken. The input is not ready while a request is in
// progress. A finished result waits in an output register, and the next
// request can be accepted meanwhile. A put of a new key takes the lowest free
// entry; valid bits are cleared at reset, so no clearing pass.
module key_value_bucket_store (
	input  logic     clk,
	input  logic     arst_n,
	kvb_req_if.sink  req,
	kvb_rsp_if.source rsp
);
	import kvb_pkg::*;

	state_t state_q, state_d;

	logic [1:0]             func_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;

	logic [IDX_W-1:0] addr_q;
	logic             issue_done_q;
	logic             cmp_en_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [VALUE_WIDTH-1:0] vout_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [DEPTH-1:0] entry_valid_q;
	logic [CNT_W-1:0] count_q, count_d;

	logic out_valid_q;
	rsp_t rsp_q;

	logic [KEY_WIDTH-1:0]   key_rd;
	logic [VALUE_WIDTH-1:0] val_rd;

	logic             accept;
	logic             scan_issue;
	logic             key_hit;
	logic             out_free;
	logic             do_commit;
	logic             key_we, val_we;
	logic [IDX_W-1:0] waddr;
	logic             set_valid, clr_valid;
	logic             full_err;

	kvb_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_q),
		.raddr (addr_q),
		.rdata (key_rd)
	);

	kvb_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (waddr),
		.wdata (value_q),
		.raddr (addr_q),
		.rdata (val_rd)
	);

	always_comb begin
		req.ready  = (state_q == ST_IDLE);
		accept     = req.valid && (state_q == ST_IDLE);
		scan_issue = (state_q == ST_SCAN) && !issue_done_q;
		key_hit    = (state_q == ST_SCAN) && cmp_en_s1 && entry_valid_q[cmp_idx_s1]
			&& (key_rd == key_q);
		out_free   = !out_valid_q || rsp.ready;
		do_commit  = 1'b0;
		state_d    = state_q;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (key_hit || (cmp_en_s1 && cmp_idx_s1 == LAST_IDX)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					do_commit = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// update decision, applied only on commit
	always_comb begin
		key_we    = 1'b0;
		val_we    = 1'b0;
		waddr     = match_idx_q;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		full_err  = 1'b0;
		count_d   = count_q;

		case (func_q)
			FUNC_PUT: begin
				if (match_q) begin
					val_we = do_commit;
				end else if (free_found_q) begin
					waddr     = free_idx_q;
					key_we    = do_commit;
					val_we    = do_commit;
					set_valid = do_commit;
					count_d   = count_q + CNT_W'(1);
				end else begin
					full_err = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (match_q) begin
					clr_valid = do_commit;
					count_d   = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_done_q  <= 1'b0;
			cmp_en_s1     <= 1'b0;
			match_q       <= 1'b0;
			free_found_q  <= 1'b0;
			entry_valid_q <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			cmp_en_s1 <= scan_issue;
			if (accept) begin
				issue_done_q <= 1'b0;
				match_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (scan_issue && addr_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end
				if (key_hit) begin
					match_q <= 1'b1;
				end
				if (scan_issue && !free_found_q && !entry_valid_q[addr_q]) begin
					free_found_q <= 1'b1;
				end
			end
			if (set_valid) begin
				entry_valid_q[waddr] <= 1'b1;
			end
			if (clr_valid) begin
				entry_valid_q[match_idx_q] <= 1'b0;
			end
			if (do_commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.payload.func;
			key_q   <= KEY_WIDTH'(req.payload.key);
			value_q <= VALUE_WIDTH'(req.payload.value_in);
			addr_q  <= '0;
		end else if (scan_issue) begin
			addr_q <= addr_q + IDX_W'(1);
		end
		cmp_idx_s1 <= addr_q;
		if (key_hit) begin
			match_idx_q <= cmp_idx_s1;
			vout_q      <= val_rd;
		end
		if (scan_issue && !free_found_q && !entry_valid_q[addr_q]) begin
			free_idx_q <= addr_q;
		end
		if (do_commit) begin
			rsp_q.hit         <= match_q;
			rsp_q.value_out   <= (func_q == FUNC_GET && match_q) ? 32'(vout_q) : 32'd0;
			rsp_q.full_error  <= full_err;
			rsp_q.entry_count <= 5'(count_d);
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = rsp_q;

endmodule

// ----- rtl/core/kvb_ram.sv -----
`timescale 1ns / 1ps

module kvb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- tb/tb_key_value_bucket_store.sv -----
`timescale 1ns / 1ps

module tb_key_value_bucket_store;
	import kvb_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int POOL_SIZE   = 24;
	localparam int SEGMENTS    = 13;
	localparam int SEG_ITEMS   = 102;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		req_t cmd;
		bit   known;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	kvb_req_if req_ch ();
	kvb_rsp_if rsp_ch ();

	key_value_bucket_store uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// bucket contents as seen from accepted requests
	logic [KEY_WIDTH-1:0]   stored_key [DEPTH];
	logic [VALUE_WIDTH-1:0] stored_val [DEPTH];
	bit                     slot_used  [DEPTH];
	int                     used_count = 0;

	rsp_t        expected_rsp [$];
	dir_row_t    directed_rows [$];
	logic [31:0] key_pool [POOL_SIZE];
	int          failures   = 0;
	int          hold_asks  = 0;
	int          holds_done = 0;
	int          stall_left = 0;
	bit          bursts_on  = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t bucket_apply(req_t r);
		rsp_t o;
		int   i;
		int   idx;
		int   free_idx;
		o = '0;
		idx = -1;
		free_idx = -1;
		for (i = 0; i < DEPTH; i++) begin
			if (slot_used[i] && stored_key[i] == r.key && idx < 0)
				idx = i;
			if (!slot_used[i] && free_idx < 0)
				free_idx = i;
		end
		o.hit = (idx >= 0);
		case (r.func)
			FUNC_GET: begin
				if (idx >= 0)
					o.value_out = stored_val[idx];
			end
			FUNC_PUT: begin
				if (idx >= 0) begin
					stored_val[idx] = r.value_in;
				end else if (free_idx >= 0) begin
					stored_key[free_idx] = r.key;
					stored_val[free_idx] = r.value_in;
					slot_used[free_idx] = 1'b1;
					used_count++;
				end else begin
					o.full_error = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (idx >= 0) begin
					slot_used[idx] = 1'b0;
					used_count--;
				end
			end
			default: ;
		endcase
		o.entry_count = 5'(used_count);
		return o;
	endfunction

	function void note_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	// live keys are preferred for lookups and removes so hits stay common
	function automatic logic [31:0] pick_key(bit prefer_live);
		int slot;
		if (prefer_live && used_count > 0 && $urandom_range(0, 1) == 1) begin
			slot = $urandom_range(0, DEPTH - 1);
			while (!slot_used[slot])
				slot = (slot + 1) % DEPTH;
			return stored_key[slot];
		end
		if ($urandom_range(0, 99) < 80)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic req_t random_req(int mix);
		req_t r;
		int   roll;
		int   put_pct;
		int   rem_pct;
		put_pct = (mix == 0) ? 55 : (mix == 1) ? 35 : 20;
		rem_pct = (mix == 0) ? 15 : (mix == 1) ? 25 : 45;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			r.func = FUNC_UNUSED;
		else if (roll < 3 + put_pct)
			r.func = FUNC_PUT;
		else if (roll < 3 + put_pct + rem_pct)
			r.func = FUNC_REMOVE;
		else
			r.func = FUNC_GET;
		r.key = pick_key(r.func != FUNC_PUT || $urandom_range(0, 4) == 0);
		roll = $urandom_range(0, 9);
		r.value_in = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : 32'($urandom);
		return r;
	endfunction

	task automatic add_row(logic [1:0] f, logic [31:0] k, logic [31:0] v, bit known,
			logic h, logic [31:0] vo, logic fe, logic [4:0] cnt);
		dir_row_t row;
		row.cmd.func = f;
		row.cmd.key = k;
		row.cmd.value_in = v;
		row.known = known;
		row.want.hit = h;
		row.want.value_out = vo;
		row.want.full_error = fe;
		row.want.entry_count = cnt;
		directed_rows.push_back(row);
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer(req_t item, bit known, rsp_t known_rsp);
		rsp_t predicted;
		req_ch.valid <= 1'b1;
		req_ch.payload <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = bucket_apply(item);
		expected_rsp.push_back(known ? known_rsp : predicted);
		@(negedge clk);
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				holds_done = hold_asks;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && bursts_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (expected_rsp.size() == 0) begin
				note_failure($sformatf("unexpected result: hit=%0d value=%h full=%0d count=%0d",
					got.hit, got.value_out, got.full_error, got.entry_count));
			end else begin
				want = expected_rsp.pop_front();
				if (got.hit !== want.hit || got.value_out !== want.value_out ||
						got.full_error !== want.full_error ||
						got.entry_count !== want.entry_count)
					note_failure($sformatf({"result mismatch: expected hit=%0d value=%h ",
						"full=%0d count=%0d, got hit=%0d value=%h full=%0d count=%0d"},
						want.hit, want.value_out, want.full_error, want.entry_count,
						got.hit, got.value_out, got.full_error, got.entry_count));
			end
		end
	end

	// ends the run when neither side moves a request for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int   i;
		int   seg;
		int   n;
		rsp_t none;
		none = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		for (i = 0; i < DEPTH; i++)
			slot_used[i] = 1'b0;

		add_row(FUNC_GET,    32'h0000_0000, 32'h0000_0000, 1, 0, 32'h0, 0, 0);
		add_row(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 32'h0, 0, 0);
		add_row(FUNC_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 32'h0, 0, 0);
		add_row(FUNC_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 32'h0, 0, 1);
		add_row(FUNC_GET,    32'h0000_0000, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 0, 1);
		// unused code reports a hit but no value
		add_row(FUNC_UNUSED, 32'h0000_0000, 32'h1234_5678, 1, 1, 32'h0, 0, 1);
		add_row(FUNC_PUT,    32'h0000_0000, 32'h0000_0000, 1, 1, 32'h0, 0, 1);
		add_row(FUNC_PUT,    32'hFFFF_FFFF, 32'hA5A5_A5A5, 1, 0, 32'h0, 0, 2);
		for (i = 1; i <= 14; i++)
			add_row(FUNC_PUT, 32'h1111_1111 * i, $urandom, 0, 0, 32'h0, 0, 0);
		// bucket is full now
		add_row(FUNC_PUT,    32'h0F0F_0F0F, 32'h0000_0001, 1, 0, 32'h0, 1, 16);
		add_row(FUNC_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 32'h0, 0, 16);
		add_row(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, 1, 32'h0, 0, 15);

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[k])
			offer(directed_rows[k].cmd, directed_rows[k].known, directed_rows[k].want);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			bursts_on = (seg % 4 != 2) && (seg < SEGMENTS - 1);
			foreach (key_pool[k])
				key_pool[k] = $urandom;
			if (seg == 3)
				hold_asks++;
			if (seg == 7) begin
				req_ch.valid <= 1'b0;
				do
					@(negedge clk);
				while (expected_rsp.size() != 0);
			end
			for (n = 0; n < SEG_ITEMS; n++) begin
				if (bursts_on && $urandom_range(0, 4) == 0) begin
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 19)) @(negedge clk);
				end
				offer(random_req(seg % 3), 1'b0, none);
			end
		end

		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_rsp.size() != 0);
		repeat (DEPTH + 4) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
